// ===== src/lbp_pkg.sv =====
// Package for the LSB-first bit packer.
// Holds the transfer payload types, mode codes and the packer-to-buffer result type.
// No dependencies.
package lbp_pkg;

    localparam logic [1:0] MODE_LSB   = 2'd0;
    localparam logic [1:0] MODE_REV   = 2'd1;
    localparam logic [1:0] MODE_BYTES = 2'd2;
    localparam logic [1:0] MODE_FLUSH = 2'd3;

    localparam logic [4:0] MAX_BIT_LEN  = 5'd16;
    localparam logic [4:0] MAX_BYTE_LEN = 5'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] value;
        logic [4:0]  length;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } out_item_t;

    // Bytes completed by one item, lowest byte first, and how many are valid.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
    } pack_res_t;

endpackage

// ===== src/lsb_first_bit_packer.sv =====
// Top level of the LSB-first bit packer: input register, packer stage, result buffer.
// Depends on lbp_pkg, lbp_packer and lbp_out_buf.
//
// Packs bit fields least significant bit first into a byte stream. Each item is
// taken into an input register and merged with the partial byte; its completed
// bytes (0 to 4) move into a result buffer that sends one byte per output
// transfer; last_byte marks the final byte of an item. An item is merged only
// once the result buffer is free, also when it completes no byte. An item yields
// up to 2 bytes for bit appends, up to 4 for byte appends and 1 for a flush.
// A flush always sends one byte.
module lsb_first_bit_packer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  lbp_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output lbp_pkg::out_item_t result
);

    lbp_pkg::in_item_t  item_reg;
    logic               item_valid_reg;
    lbp_pkg::pack_res_t res;
    logic               buf_free;
    logic               go;

    assign go         = item_valid_reg && buf_free;
    assign item_stall = item_valid_reg && !go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_valid && !item_stall)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (go)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
    end

    lbp_packer u_packer (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .item  (item_reg),
        .res   (res)
    );

    lbp_out_buf u_out_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (go && (res.count != 3'd0)),
        .res   (res),
        .free  (buf_free),
        .valid (result_valid),
        .stall (result_stall),
        .item  (result)
    );

endmodule

// ===== src/lbp_packer.sv =====
// Packer stage: holds partial byte and bit position, merges one item per cycle on go.
// Depends on lbp_pkg.
module lbp_packer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  lbp_pkg::in_item_t item,
    output lbp_pkg::pack_res_t res
);

    logic [7:0]  pending_reg;
    logic [7:0]  pending_next;
    logic [2:0]  bit_count_reg;
    logic [2:0]  bit_count_next;

    logic [4:0]  len_bits;
    logic [2:0]  len_bytes;
    logic [5:0]  nbits;
    logic [15:0] rev;
    logic [15:0] v16;
    logic [15:0] mask16;
    logic [31:0] mask32;
    logic [31:0] bits;
    logic [39:0] merged;
    logic [5:0]  total;

    always_comb
    begin
        len_bits  = (item.length > lbp_pkg::MAX_BIT_LEN) ? lbp_pkg::MAX_BIT_LEN : item.length;
        len_bytes = (item.length > lbp_pkg::MAX_BYTE_LEN) ? lbp_pkg::MAX_BYTE_LEN[2:0]
                                                          : item.length[2:0];
        for (int i = 0; i < 16; i++)
        begin
            rev[i] = item.value[15 - i];
        end
        for (int k = 0; k < 4; k++)
        begin
            mask32[k*8 +: 8] = (3'(k) < len_bytes) ? 8'hFF : 8'h00;
        end
        mask16 = 16'((17'd1 << len_bits) - 17'd1);
        v16    = (item.mode == lbp_pkg::MODE_REV) ? (rev >> (5'd16 - len_bits))
                                                  : item.value[15:0];
        if (item.mode == lbp_pkg::MODE_BYTES)
        begin
            nbits = {len_bytes, 3'b000};
            bits  = item.value & mask32;
        end
        else
        begin
            nbits = {1'b0, len_bits};
            bits  = {16'h0000, v16 & mask16};
        end
        merged = ({8'h00, bits} << bit_count_reg) | {32'h0, pending_reg};
        total  = {3'b000, bit_count_reg} + nbits;

        if (item.mode == lbp_pkg::MODE_FLUSH)
        begin
            res.bytes      = {24'h0, pending_reg};
            res.count      = 3'd1;
            pending_next   = 8'h00;
            bit_count_next = 3'd0;
        end
        else
        begin
            res.bytes      = merged[31:0];
            res.count      = total[5:3];
            bit_count_next = total[2:0];
            case (total[5:3])
                3'd0:    pending_next = merged[7:0];
                3'd1:    pending_next = merged[15:8];
                3'd2:    pending_next = merged[23:16];
                3'd3:    pending_next = merged[31:24];
                default: pending_next = merged[39:32];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 8'h00;
            bit_count_reg <= 3'd0;
        end
        else if (go)
        begin
            pending_reg   <= pending_next;
            bit_count_reg <= bit_count_next;
        end
    end

endmodule

// ===== src/lbp_out_buf.sv =====
// Result buffer: holds up to four completed bytes and shifts them out one per transfer.
// Depends on lbp_pkg.
module lbp_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  lbp_pkg::pack_res_t res,
    output logic               free,
    output logic               valid,
    input  logic               stall,
    output lbp_pkg::out_item_t item
);

    logic [3:0][7:0] bytes_reg;
    logic [2:0]      count_reg;
    logic            take;

    assign valid          = (count_reg != 3'd0);
    assign take           = valid && !stall;
    assign free           = (count_reg == 3'd0) || ((count_reg == 3'd1) && !stall);
    assign item.out_byte  = bytes_reg[0];
    assign item.last_byte = (count_reg == 3'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
        end
        else if (load)
        begin
            count_reg <= res.count;
        end
        else if (take)
        begin
            count_reg <= count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= res.bytes;
        end
        else if (take)
        begin
            bytes_reg <= {8'h00, bytes_reg[3:1]};
        end
    end

endmodule

// ===== tb/lbp_stream_checker.sv =====
// Stream checker for lsb_first_bit_packer: watches both transfer channels, packs each
// accepted item into the expected byte stream and compares every result transfer.
// Depends on lbp_pkg.
module lbp_stream_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_stall,
    input  lbp_pkg::in_item_t  item,
    input  logic               result_valid,
    input  logic               result_stall,
    input  lbp_pkg::out_item_t result,
    output int                 bytes_owed,
    output int                 errors
);

    lbp_pkg::out_item_t stream_q[$];
    logic [7:0]         part_byte;
    int                 part_fill;

    // Appends one item to the expected stream and advances the partial byte.
    task automatic pack_item(input lbp_pkg::in_item_t it);
        logic [31:0]        bits;
        logic [31:0]        rev;
        int                 nbits;
        int                 made;
        lbp_pkg::out_item_t b;
        made = 0;
        if (it.mode == lbp_pkg::MODE_FLUSH)
        begin
            b.out_byte  = part_byte;
            b.last_byte = 1'b1;
            stream_q.push_back(b);
            part_byte = '0;
            part_fill = 0;
            return;
        end
        if (it.mode == lbp_pkg::MODE_BYTES)
        begin
            bits  = it.value;
            nbits = (it.length > lbp_pkg::MAX_BYTE_LEN) ? 32 : 8 * int'(it.length);
        end
        else
        begin
            bits  = {16'h0000, it.value[15:0]};
            nbits = (it.length > lbp_pkg::MAX_BIT_LEN) ? 16 : int'(it.length);
            if (it.mode == lbp_pkg::MODE_REV)
            begin
                rev = '0;
                for (int i = 0; i < nbits; i++)
                begin
                    rev = {rev[30:0], bits[i]};
                end
                bits = rev;
            end
        end
        for (int i = 0; i < nbits; i++)
        begin
            part_byte[part_fill] = bits[i];
            part_fill++;
            if (part_fill == 8)
            begin
                b.out_byte  = part_byte;
                b.last_byte = 1'b0;
                stream_q.push_back(b);
                made++;
                part_byte = '0;
                part_fill = 0;
            end
        end
        if (made > 0)
        begin
            b = stream_q.pop_back();
            b.last_byte = 1'b1;
            stream_q.push_back(b);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        lbp_pkg::out_item_t want;
        if (!rst_n)
        begin
            stream_q.delete();
            part_byte = '0;
            part_fill = 0;
            errors    = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                pack_item(item);
            if (result_valid && !result_stall)
            begin
                if (stream_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected byte: expected none, got out_byte %h last_byte %b",
                             $time, result.out_byte, result.last_byte);
                end
                else
                begin
                    want = stream_q.pop_front();
                    if (result.out_byte !== want.out_byte)
                    begin
                        errors++;
                        $display("%0t: out_byte mismatch: expected %h, got %h",
                                 $time, want.out_byte, result.out_byte);
                    end
                    if (result.last_byte !== want.last_byte)
                    begin
                        errors++;
                        $display("%0t: last_byte mismatch: expected %b, got %b",
                                 $time, want.last_byte, result.last_byte);
                    end
                end
            end
        end
        bytes_owed = stream_q.size();
    end

endmodule

// ===== tb/tb_lsb_first_bit_packer.sv =====
// Testbench top for lsb_first_bit_packer: clock, reset, directed and random items,
// random idling on both channels, receiver hold-off, final verdict.
// Depends on lbp_pkg, lsb_first_bit_packer and lbp_stream_checker.
module tb_lsb_first_bit_packer;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 120;
    localparam int HOLD_CYCLES  = 60;
    localparam int BURST_ITEMS  = 25;
    localparam int TAIL_CYCLES  = 20;
    localparam int LIMIT_CYCLES = 200000;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    lbp_pkg::in_item_t  item         = '0;
    logic               result_stall = 1'b0;
    logic               item_stall;
    logic               result_valid;
    lbp_pkg::out_item_t result;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_req      = 1'b0;
    int   bytes_owed;
    int   errors;

    always #(HALF_PERIOD) clk = ~clk;

    lsb_first_bit_packer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    lbp_stream_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .bytes_owed   (bytes_owed),
        .errors       (errors)
    );

    function automatic lbp_pkg::in_item_t mk(input logic [1:0] mode,
                                             input logic [31:0] value,
                                             input logic [4:0] length);
        lbp_pkg::in_item_t it;
        it.mode   = mode;
        it.value  = value;
        it.length = length;
        return it;
    endfunction

    function automatic lbp_pkg::in_item_t rand_item();
        lbp_pkg::in_item_t it;
        int                pick;
        pick     = $urandom_range(99);
        it.value = $urandom();
        if (pick < 40)
        begin
            it.mode   = lbp_pkg::MODE_LSB;
            it.length = 5'($urandom_range(16, 1));
        end
        else if (pick < 70)
        begin
            it.mode   = lbp_pkg::MODE_REV;
            it.length = 5'($urandom_range(16, 1));
        end
        else if (pick < 85)
        begin
            it.mode   = lbp_pkg::MODE_BYTES;
            it.length = 5'($urandom_range(4, 0));
        end
        else if (pick < 93)
        begin
            it.mode   = lbp_pkg::MODE_FLUSH;
            it.length = 5'($urandom_range(31, 0));
        end
        else
        begin
            // any length from 0 to 31, including zero and oversized lengths
            case ($urandom_range(2))
                0:       it.mode = lbp_pkg::MODE_LSB;
                1:       it.mode = lbp_pkg::MODE_REV;
                default: it.mode = lbp_pkg::MODE_BYTES;
            endcase
            it.length = 5'($urandom_range(31, 0));
        end
        return it;
    endfunction

    // Entered and left at a falling edge.
    task automatic send_item(input lbp_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(negedge clk);
        while (bytes_owed != 0)
            @(negedge clk);
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        #(2 * HALF_PERIOD * LIMIT_CYCLES);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 38;
        recv_idle_pct = 76;
        send_item(mk(lbp_pkg::MODE_LSB,   32'h0000FFFF, 5'd0));
        send_item(mk(lbp_pkg::MODE_LSB,   32'hFFFFFFFF, 5'd16));
        send_item(mk(lbp_pkg::MODE_REV,   32'h00000001, 5'd16));
        send_item(mk(lbp_pkg::MODE_REV,   32'h00000005, 5'd3));
        send_item(mk(lbp_pkg::MODE_LSB,   32'h0000001B, 5'd5));
        send_item(mk(lbp_pkg::MODE_FLUSH, 32'h00000000, 5'd0));
        send_item(mk(lbp_pkg::MODE_LSB,   32'hABCD1234, 5'd31));
        send_item(mk(lbp_pkg::MODE_REV,   32'h5555AAAA, 5'd17));
        send_item(mk(lbp_pkg::MODE_BYTES, 32'hFFFFFFFF, 5'd0));
        send_item(mk(lbp_pkg::MODE_BYTES, 32'h12345678, 5'd4));
        send_item(mk(lbp_pkg::MODE_LSB,   32'h00000003, 5'd2));
        send_item(mk(lbp_pkg::MODE_BYTES, 32'h89ABCDEF, 5'd31));
        send_item(mk(lbp_pkg::MODE_BYTES, 32'hCAFEF00D, 5'd1));
        send_item(mk(lbp_pkg::MODE_FLUSH, 32'hFFFFFFFF, 5'd31));
        send_item(mk(lbp_pkg::MODE_FLUSH, 32'h00000000, 5'd0));
        send_item(mk(lbp_pkg::MODE_REV,   32'h0000FFFF, 5'd16));
        send_item(mk(lbp_pkg::MODE_LSB,   32'h00000000, 5'd16));
        send_item(mk(lbp_pkg::MODE_LSB,   32'h0000007F, 5'd7));
        send_item(mk(lbp_pkg::MODE_REV,   32'h00000001, 5'd1));
        send_item(mk(lbp_pkg::MODE_BYTES, 32'h00000000, 5'd3));
        send_item(mk(lbp_pkg::MODE_REV,   32'hFFFF0000, 5'd9));
        send_item(mk(lbp_pkg::MODE_FLUSH, 32'h00000000, 5'd0));
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 38;
                    recv_idle_pct = 76;
                end
                1:
                begin
                    send_idle_pct = 76;
                    recv_idle_pct = 38;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 2)
            begin
                // receiver blocks while the sender keeps offering transfers
                hold_req = 1'b1;
                for (int n = 0; n < BURST_ITEMS; n++)
                    send_item(rand_item());
            end
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
                send_item(rand_item());
            drain();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
